FILE: sv/mono_framebuffer_draw_engine_core_assert.svh
// assertion macros for the draw engine checker
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_ASSERT_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

FILE: sv/mfde_pkg.sv
package mfde_pkg;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    typedef enum logic [2:0] {
        FN_PIXEL = 3'd0,
        FN_FILL  = 3'd1,
        FN_RECT  = 3'd2,
        FN_LINE  = 3'd3,
        FN_HLINE = 3'd4,
        FN_VLINE = 3'd5,
        FN_READ  = 3'd6,
        FN_NOP   = 3'd7
    } func_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // one queued command word
    typedef struct packed {
        func_t      func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       ink;
        logic       fill_inside;
        logic [9:0] byte_index;
    } cmd_t;
endpackage

FILE: sv/mfde_front.sv
module mfde_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mfde_pkg::cmd_t  cmd_in,
    output logic            cmd_valid,
    input  logic            cmd_take,
    output mfde_pkg::cmd_t  cmd_out
);
    // two-entry command queue
    mfde_pkg::cmd_t q_reg [2];
    logic           rd_reg, rd_next;
    logic           wr_reg, wr_next;
    logic [1:0]     cnt_reg, cnt_next;
    mfde_pkg::cmd_t cls;
    logic           do_push, do_pop;

    assign full      = cnt_reg == 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd_out   = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        cls = cmd_in;
        if (cmd_in.func == mfde_pkg::FN_NOP)
            cls.func = mfde_pkg::FN_NOP;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        wr_next  = do_push ? !wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: sv/mfde_back.sv
module mfde_back
#(
    parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_take,
    input  mfde_pkg::cmd_t  cmd,
    input  logic [7:0]      disp_w,
    input  logic [6:0]      disp_h,
    output logic            res_valid,
    input  logic            res_take,
    output logic [7:0]      res_data
);
    localparam int PAGES = (MAX_HEIGHT + 7) / 8;
    localparam int DEPTH = MAX_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_GEN, S_RD, S_MOD, S_WR, S_READ1, S_READ2, S_RES
    } state_t;

    logic [7:0] mem [DEPTH];
    state_t     state_reg;
    logic [AW:0] clr_reg;
    mfde_pkg::cmd_t c_reg;
    logic [9:0] uw_reg;   // used width
    logic [9:0] uh_reg;   // used height, whole pages
    // generic walker: x,y current; phase for rect sections
    logic signed [10:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [10:0] dx_reg, dy_reg, err_reg;
    logic signed [10:0] sx_reg, sy_reg;
    logic [2:0]  ph_reg;
    logic [AW:0] fi_reg;
    logic [AW:0] fn_reg;
    logic [AW-1:0] addr_reg;
    logic [2:0]  bit_reg;
    logic        hit_reg;
    logic        last_reg;
    logic [7:0]  rdat_reg;
    logic [7:0]  data_reg;

    logic [10:0] wcl, hcl;
    assign wcl = (disp_w > MAX_WIDTH[7:0] && MAX_WIDTH < 256) ? 11'(MAX_WIDTH) : {3'd0, disp_w};
    assign hcl = (11'(disp_h) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {4'd0, disp_h};

    // store byte address of current point
    logic        in_rng;
    logic [17:0] pa;
    assign in_rng = !x_reg[10] && !y_reg[10] && ($unsigned(x_reg) < 11'(uw_reg))
                    && ($unsigned(y_reg) < 11'(uh_reg));
    assign pa = 18'(y_reg[10:3]) * 18'(uw_reg) + 18'(x_reg);

    // bresenham step
    logic signed [11:0] e2;
    assign e2 = {err_reg, 1'b0};

    assign cmd_take  = state_reg == S_IDLE && cmd_valid;
    assign res_valid = state_reg == S_RES;
    assign res_data  = data_reg;

    // fill loads its constant byte while the walker hands over the address
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg[AW-1:0]] <= 8'h00;
        else if (state_reg == S_WR && hit_reg)
            mem[addr_reg] <= rdat_reg;
        if (state_reg == S_MOD)
            rdat_reg <= c_reg.ink ? (rdat_reg | (8'd1 << bit_reg))
                                  : (rdat_reg & ~(8'd1 << bit_reg));
        else if (state_reg == S_GEN && c_reg.func == mfde_pkg::FN_FILL)
            rdat_reg <= c_reg.ink ? 8'hFF : 8'h00;
        else
            rdat_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (cmd_valid)
                    begin
                        c_reg     <= cmd;
                        uw_reg    <= wcl[9:0];
                        uh_reg    <= {hcl[9:3], 3'd0};
                        data_reg  <= 8'h00;
                        state_reg <= S_SETUP;
                    end
                S_SETUP:
                begin
                    ph_reg <= 3'd0;
                    x_reg  <= 11'(c_reg.pos_x);
                    y_reg  <= 11'(c_reg.pos_y);
                    x1_reg <= 11'(c_reg.end_x);
                    y1_reg <= 11'(c_reg.end_y);
                    dx_reg <= (c_reg.end_x > c_reg.pos_x) ? 11'(c_reg.end_x - c_reg.pos_x)
                                                           : 11'(c_reg.pos_x - c_reg.end_x);
                    dy_reg <= (c_reg.end_y > c_reg.pos_y) ? 11'(c_reg.end_y - c_reg.pos_y)
                                                           : 11'(c_reg.pos_y - c_reg.end_y);
                    sx_reg <= (c_reg.pos_x < c_reg.end_x) ? 11'sd1 : -11'sd1;
                    sy_reg <= (c_reg.pos_y < c_reg.end_y) ? 11'sd1 : -11'sd1;
                    err_reg <= 11'(c_reg.end_x > c_reg.pos_x ? c_reg.end_x - c_reg.pos_x
                                                              : c_reg.pos_x - c_reg.end_x)
                             - 11'(c_reg.end_y > c_reg.pos_y ? c_reg.end_y - c_reg.pos_y
                                                              : c_reg.pos_y - c_reg.end_y);
                    fi_reg <= '0;
                    fn_reg <= (AW+1)'(uw_reg) * (AW+1)'(uh_reg[9:3]);
                    priority case (c_reg.func)
                        mfde_pkg::FN_READ:  state_reg <= S_READ1;
                        mfde_pkg::FN_HLINE: state_reg <= (c_reg.pos_x > c_reg.end_x) ? S_RES : S_GEN;
                        mfde_pkg::FN_VLINE: state_reg <= (c_reg.pos_y > c_reg.end_y) ? S_RES : S_GEN;
                        mfde_pkg::FN_RECT:
                            state_reg <= (c_reg.rect_width == 8'd0 || c_reg.rect_height == 8'd0)
                                         ? S_RES : S_GEN;
                        mfde_pkg::FN_FILL:
                            state_reg <= (uw_reg == 10'd0 || uh_reg == 10'd0) ? S_RES : S_GEN;
                        mfde_pkg::FN_NOP:   state_reg <= S_RES;
                        default:            state_reg <= S_GEN;
                    endcase
                end
                S_GEN:
                begin
                    // latch target of current point, then advance walker
                    if (c_reg.func == mfde_pkg::FN_FILL)
                    begin
                        addr_reg <= fi_reg[AW-1:0];
                        hit_reg  <= 1'b1;
                        fi_reg   <= fi_reg + 1'b1;
                        last_reg <= (fi_reg + 1'b1 >= fn_reg)
                                    || (fi_reg + 1'b1 >= (AW+1)'(DEPTH));
                        state_reg <= S_WR;
                    end
                    else
                    begin
                        addr_reg <= AW'(pa);
                        bit_reg  <= y_reg[2:0];
                        hit_reg  <= in_rng && (pa < 18'(DEPTH));
                        state_reg <= S_RD;
                        unique case (c_reg.func)
                            mfde_pkg::FN_HLINE:
                            begin
                                last_reg <= x_reg == x1_reg;
                                x_reg <= x_reg + 11'sd1;
                            end
                            mfde_pkg::FN_VLINE:
                            begin
                                last_reg <= y_reg == y1_reg;
                                y_reg <= y_reg + 11'sd1;
                            end
                            mfde_pkg::FN_LINE:
                            begin
                                last_reg <= (x_reg == x1_reg) && (y_reg == y1_reg);
                                if (e2 > -12'(dy_reg))
                                begin
                                    x_reg <= x_reg + sx_reg;
                                end
                                if (e2 < 12'(dx_reg))
                                    y_reg <= y_reg + sy_reg;
                                err_reg <= err_reg - ((e2 > -12'(dy_reg)) ? dy_reg : 11'sd0)
                                                   + ((e2 < 12'(dx_reg)) ? dx_reg : 11'sd0);
                            end
                            mfde_pkg::FN_RECT:
                            begin
                                // phases: top, bottom, left, right, interior
                                last_reg <= 1'b0;
                                priority case (ph_reg)
                                    3'd0, 3'd1:
                                        if (x_reg == 11'(c_reg.pos_x) + 11'(c_reg.rect_width)
                                            - 11'd1)
                                        begin
                                            ph_reg <= ph_reg + 1'b1;
                                            x_reg  <= ph_reg == 3'd0 ? 11'(c_reg.pos_x)
                                                      : 11'(c_reg.pos_x);
                                            y_reg  <= ph_reg == 3'd0
                                                ? 11'(c_reg.pos_y) + 11'(c_reg.rect_height)
                                                  - 11'd1
                                                : 11'(c_reg.pos_y);
                                        end
                                        else
                                            x_reg <= x_reg + 11'sd1;
                                    3'd2, 3'd3:
                                        if (y_reg == 11'(c_reg.pos_y) + 11'(c_reg.rect_height)
                                            - 11'd1)
                                        begin
                                            ph_reg <= ph_reg + 1'b1;
                                            y_reg  <= ph_reg == 3'd2 ? 11'(c_reg.pos_y)
                                                      : 11'(c_reg.pos_y) + 11'sd1;
                                            x_reg  <= ph_reg == 3'd2
                                                ? 11'(c_reg.pos_x) + 11'(c_reg.rect_width)
                                                  - 11'd1
                                                : 11'(c_reg.pos_x) + 11'sd1;
                                            if (ph_reg == 3'd3 && (!c_reg.fill_inside
                                                || c_reg.rect_width < 8'd3
                                                || c_reg.rect_height < 8'd3))
                                                last_reg <= 1'b1;
                                        end
                                        else
                                            y_reg <= y_reg + 11'sd1;
                                    default:
                                        if (y_reg == 11'(c_reg.pos_y) + 11'(c_reg.rect_height)
                                            - 11'd2)
                                        begin
                                            y_reg <= 11'(c_reg.pos_y) + 11'sd1;
                                            x_reg <= x_reg + 11'sd1;
                                            if (x_reg == 11'(c_reg.pos_x)
                                                + 11'(c_reg.rect_width) - 11'd2)
                                                last_reg <= 1'b1;
                                        end
                                        else
                                            y_reg <= y_reg + 11'sd1;
                                endcase
                                if (ph_reg == 3'd4 && (!c_reg.fill_inside
                                    || c_reg.rect_width < 8'd3 || c_reg.rect_height < 8'd3))
                                    hit_reg <= 1'b0;
                            end
                            default: last_reg <= 1'b1;
                        endcase
                    end
                end
                S_RD:  state_reg <= S_MOD;
                S_MOD: state_reg <= S_WR;
                S_WR:  state_reg <= last_reg ? S_RES : S_GEN;
                S_READ1:
                begin
                    addr_reg  <= AW'(c_reg.byte_index);
                    hit_reg   <= 32'(c_reg.byte_index) < DEPTH;
                    state_reg <= S_READ2;
                end
                S_READ2: state_reg <= S_MOD;
                S_RES:
                    if (res_take)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            // read command: capture data and skip the write-back
            if (state_reg == S_MOD && c_reg.func == mfde_pkg::FN_READ)
            begin
                data_reg  <= hit_reg ? rdat_reg : 8'h00;
                hit_reg   <= 1'b0;
                last_reg  <= 1'b1;
            end
        end
    end
endmodule

FILE: sv/mfde_out.sv
module mfde_out
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    output logic       res_take,
    input  logic [7:0] res_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] read_data
);
    // single output register
    logic       vld_reg;
    logic [7:0] d_reg;

    assign empty     = !vld_reg;
    assign read_data = d_reg;
    assign res_take  = res_valid && (!vld_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (res_take)
            vld_reg <= 1'b1;
        else if (pop)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            d_reg <= res_data;
    end
endmodule

FILE: sv/mono_framebuffer_draw_engine_core.sv
// monochrome page-organized framebuffer draw engine
// command channel: push/full, one word per command (func and operands)
// result channel: empty/pop, one word per command: done_res and read_data
// config: cfg_we/cfg_index/cfg_data write width (index 0) or height (index 1)
// commands enter a two-word queue; the back end runs one command at a time
// each drawn pixel is a read-modify-write of one store byte (GEN, RD, MOD, WR)
// fill writes a constant byte without reading, over width*pages bytes
// a read steps through READ1, READ2, MOD and WR to the result; a no-op goes from setup to the result
// after reset the store is swept to zero, one byte a cycle, over MAX_WIDTH*pages
// bytes (1024 by default); commands queue but do not start meanwhile
// when pop is held low the result stays in the output register, the back end
// waits for space, and full rises once the queue holds two commands
module mono_framebuffer_draw_engine_core
#(
    parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] func,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] end_x,
    input  logic [7:0] end_y,
    input  logic [7:0] rect_width,
    input  logic [7:0] rect_height,
    input  logic       ink,
    input  logic       fill_inside,
    input  logic [9:0] byte_index,
    output logic       empty,
    input  logic       pop,
    output logic       done_res,
    output logic [7:0] read_data,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);
    mfde_pkg::cmd_t cmd_in, cmd_q;
    logic           cmd_valid, cmd_take;
    logic           res_valid, res_take;
    logic [7:0]     res_data;
    logic [7:0]     width_reg;
    logic [6:0]     height_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfde_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                mfde_pkg::CFG_HEIGHT: height_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd_in.func        = mfde_pkg::func_t'(func);
        cmd_in.pos_x       = pos_x;
        cmd_in.pos_y       = pos_y;
        cmd_in.end_x       = end_x;
        cmd_in.end_y       = end_y;
        cmd_in.rect_width  = rect_width;
        cmd_in.rect_height = rect_height;
        cmd_in.ink         = ink;
        cmd_in.fill_inside = fill_inside;
        cmd_in.byte_index  = byte_index;
    end

    assign done_res = 1'b1;

    mfde_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q)
    );

    mfde_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd_q), .disp_w(width_reg), .disp_h(height_reg),
        .res_valid(res_valid), .res_take(res_take), .res_data(res_data)
    );

    mfde_out u_out
    (
        .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_take(res_take),
        .res_data(res_data), .empty(empty), .pop(pop), .read_data(read_data)
    );
endmodule

FILE: sv/mfde_checker.sv
`include "mono_framebuffer_draw_engine_core_assert.svh"
module mfde_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] read_data
);
    `CHK_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(read_data))
    `CHK_NEXT(a_nofull, clk, rst_n, !full && !push, !full)
    `CHK_IMPL(a_known, clk, rst_n, !empty, !$isunknown(read_data))
endmodule

bind mono_framebuffer_draw_engine_core mfde_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .read_data(read_data)
);
